[src/tsprr_pkg.sv]
// Shared types and constants of the task slot pool scheduler.
`default_nettype none
package tsprr_pkg;

  localparam int IN_W  = 72;
  localparam int OUT_W = 264;
  localparam int GRP_W = 32;

  localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_SCHED  = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_SLICE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_GRP,
    ST_C_WORD,
    ST_C_BIT,
    ST_C_MUL,
    ST_S_RD,
    ST_S_GEN,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic grp;
    logic word;
    logic bitsel;
    logic mul;
    logic rd;
    logic gen;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

[src/tsprr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsprr_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/tsprr_ctrl.sv]
// Controller state machine sequencing create, free, tick and schedule.
`default_nettype none
module tsprr_ctrl import tsprr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_op,
  output logic            in_tready,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_op)
            OP_CREATE: state_nxt = ST_C_GRP;
            OP_SCHED:  state_nxt = ST_S_RD;
            default:   state_nxt = ST_EXEC;
          endcase
        end
      end
      ST_C_GRP: begin
        cmd.grp   = 1'b1;
        state_nxt = ST_C_WORD;
      end
      ST_C_WORD: begin
        cmd.word  = 1'b1;
        state_nxt = ST_C_BIT;
      end
      ST_C_BIT: begin
        cmd.bitsel = 1'b1;
        state_nxt  = ST_C_MUL;
      end
      ST_C_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_S_GEN;
      end
      ST_S_GEN: begin
        cmd.gen   = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[src/tsprr_dp.sv]
// Datapath: slot bitmap, generation and ready-queue memories, config and result register.
`default_nettype none
module tsprr_dp import tsprr_pkg::*; #(
  parameter int MAX_TASKS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [47:0]      cfg_wdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata
);

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int NG  = (MAX_TASKS + GRP_W - 1) / GRP_W;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int BIW = $clog2(GRP_W);
  localparam int MW  = 21 + IW + 1;

  logic [1:0]      op_r;
  logic [63:0]     fid_r;
  logic [47:0]     base_r;
  logic [20:0]     size_r;
  logic [15:0]     tslice_r;
  logic [MAX_TASKS-1:0] used_r;
  logic [NG*GRP_W-1:0]  used_pad;
  logic [NG-1:0]   gf_r;
  logic [GRP_W-1:0] word_r;
  logic [GIW-1:0]  grp_r;
  logic            any_r;
  logic [IW-1:0]   slot_r;
  logic            found_r;
  logic [MW-1:0]   mul_r;
  logic            gen0w_r;
  logic [CW-1:0]   used_cnt_r;
  logic [31:0]     next_gen_r;
  logic [IW-1:0]   head_r, tail_r;
  logic [CW-1:0]   cnt_r;
  logic [IW-1:0]   run_slot_r, run_slot_nxt;
  logic [31:0]     run_gen_r, run_gen_nxt;
  logic [15:0]     slice_r, slice_nxt;
  logic [IW-1:0]   pop_slot_r;
  logic            out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [IW-1:0]   fifo_q;
  logic [31:0]     gen_q;
  logic            fifo_we, gen_we;
  logic [IW-1:0]   fifo_wdata;

  genvar gi;
  for (gi = 0; gi < NG * GRP_W; gi++) begin : g_pad
    if (gi < MAX_TASKS) begin : g_real
      assign used_pad[gi] = used_r[gi];
    end else begin : g_fill
      assign used_pad[gi] = 1'b1;
    end
  end

  tsprr_ram #(.W(IW), .D(MAX_TASKS)) u_fifo_ram (
    .clk(clk), .we(fifo_we), .waddr(tail_r), .wdata(fifo_wdata),
    .re(cmd.rd), .raddr(head_r), .rdata(fifo_q)
  );

  tsprr_ram #(.W(32), .D(MAX_TASKS)) u_gen_ram (
    .clk(clk), .we(gen_we), .waddr(slot_r), .wdata(next_gen_r),
    .re(cmd.gen), .raddr(fifo_q), .rdata(gen_q)
  );

  logic [NG-1:0]    gf_nxt;
  logic [GIW-1:0]   g_sel;
  logic [BIW-1:0]   b_sel;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gf_nxt[g] = ~&used_pad[g*GRP_W +: GRP_W];
    end
    g_sel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (gf_r[g]) g_sel = GIW'(g);
    end
    b_sel = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (word_r[b]) b_sel = BIW'(b);
    end
  end

  logic [1:0]  sts;
  logic [63:0] new_id, top, prev_id, run_id;
  logic        sw, expired, create_ok, push_ok, idx_ok, fifo_ne;
  logic [IW-1:0] idx;
  logic [31:0] pop_gen;
  logic [IW-1:0] tail_adv, head_adv;

  always_comb begin
    idx       = fid_r[IW-1:0];
    idx_ok    = fid_r[31:0] < 32'(MAX_TASKS);
    create_ok = found_r && (used_cnt_r < CW'(MAX_TASKS));
    push_ok   = cnt_r < CW'(MAX_TASKS);
    fifo_ne   = cnt_r != '0;
    tail_adv  = (tail_r == IW'(MAX_TASKS - 1)) ? '0 : tail_r + IW'(1);
    head_adv  = (head_r == IW'(MAX_TASKS - 1)) ? '0 : head_r + IW'(1);
    pop_gen   = '0;
    if (used_r[pop_slot_r]) begin
      pop_gen = ((pop_slot_r == '0) && !gen0w_r) ? 32'd1 : gen_q;
    end
    prev_id      = {run_gen_r, 32'(run_slot_r)};
    sts          = STS_OK;
    new_id       = '0;
    top          = '0;
    sw           = 1'b0;
    run_gen_nxt  = run_gen_r;
    run_slot_nxt = run_slot_r;
    slice_nxt    = slice_r;
    case (op_r)
      OP_CREATE: begin
        if (!create_ok) begin
          sts = STS_FULL;
        end else begin
          new_id = {next_gen_r, 32'(slot_r)};
          top    = {16'd0, base_r} + 64'(mul_r);
          if (slot_r == run_slot_r) run_gen_nxt = next_gen_r;
        end
      end
      OP_FREE: begin
        if (idx_ok && (idx == run_slot_r)) run_gen_nxt = '0;
      end
      OP_TICK: begin
        if (slice_r != '0) slice_nxt = slice_r - 16'd1;
      end
      OP_SCHED: begin
        if (!fifo_ne) begin
          sts = STS_EMPTY;
        end else begin
          sw           = 1'b1;
          run_slot_nxt = pop_slot_r;
          run_gen_nxt  = pop_gen;
          slice_nxt    = tslice_r;
        end
      end
      default: sts = STS_OK;
    endcase
    expired    = slice_nxt == '0;
    run_id     = {run_gen_nxt, 32'(run_slot_nxt)};
    gen_we     = cmd.exec && (op_r == OP_CREATE) && create_ok;
    fifo_we    = cmd.exec && (((op_r == OP_CREATE) && create_ok && push_ok) ||
                              ((op_r == OP_SCHED) && fifo_ne));
    fifo_wdata = (op_r == OP_CREATE) ? slot_r : run_slot_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tdata[1:0];
      fid_r <= in_tdata[65:2];
    end
    if (cmd.grp) gf_r <= gf_nxt;
    if (cmd.word) begin
      grp_r  <= g_sel;
      word_r <= ~used_pad[g_sel*GRP_W +: GRP_W];
      any_r  <= |gf_r;
    end
    if (cmd.bitsel) begin
      slot_r  <= IW'(32'(grp_r) * GRP_W + 32'(b_sel));
      found_r <= any_r;
    end
    if (cmd.mul) begin
      mul_r <= MW'(size_r) * MW'({1'b0, slot_r} + (IW+1)'(1));
    end
    if (cmd.gen) pop_slot_r <= fifo_q;
    if (cmd.exec) out_data_r <= OUT_W'({expired, sw, prev_id, run_id, top, new_id, sts});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      size_r      <= 21'd8192;
      tslice_r    <= 16'd5;
      used_r      <= MAX_TASKS'(1);
      gen0w_r     <= 1'b0;
      used_cnt_r  <= CW'(1);
      next_gen_r  <= 32'd2;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      run_slot_r  <= '0;
      run_gen_r   <= 32'd1;
      slice_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE:  base_r   <= cfg_wdata;
          CFG_SIZE:  size_r   <= cfg_wdata[20:0];
          CFG_SLICE: tslice_r <= cfg_wdata[15:0];
          default:   ;
        endcase
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
        run_slot_r  <= run_slot_nxt;
        run_gen_r   <= run_gen_nxt;
        slice_r     <= slice_nxt;
        case (op_r)
          OP_CREATE: begin
            if (create_ok) begin
              used_r[slot_r] <= 1'b1;
              if (slot_r == '0) gen0w_r <= 1'b1;
              used_cnt_r <= used_cnt_r + CW'(1);
              next_gen_r <= (next_gen_r == GEN_MAX) ? 32'd1 : next_gen_r + 32'd1;
              if (push_ok) begin
                tail_r <= tail_adv;
                cnt_r  <= cnt_r + CW'(1);
              end
            end
          end
          OP_FREE: begin
            if (idx_ok) begin
              used_r[idx] <= 1'b0;
              if (used_cnt_r != '0) used_cnt_r <= used_cnt_r - CW'(1);
            end
          end
          OP_SCHED: begin
            if (fifo_ne) begin
              head_r <= head_adv;
              tail_r <= tail_adv;
            end
          end
          default: ;
        endcase
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule
`default_nettype wire

[src/task_slot_pool_round_robin.sv]
// Top level of the task slot pool with round-robin ready queue and time slice.
// Input words (in_*) carry one operation: create, free, timer tick or schedule.
// Every accepted word yields exactly one result word on out_*, in order.
// Path from accept to result valid: create runs a two-level free-slot search
// over 32-slot groups, then the stack-top multiply; schedule reads the ready
// queue, then the generation of the popped slot; free and tick go straight to
// execution. One word is in work at a time; in_tready is high only when idle.
// The result waits in an output register; a new word may be accepted while it
// waits, but its result is held back until out_tready frees the register.
// Configuration (cfg_*) writes one of stack base, stack size and time slice
// per write, chosen by cfg_index; write only while idle. Reset (synchronous,
// active low) marks slot 0 as the running task with generation 1, empties the
// ready queue and loads the register defaults; no clearing pass is needed.
`default_nettype none
module task_slot_pool_round_robin import tsprr_pkg::*; #(
  parameter int MAX_TASKS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // operation[1:0], free_id[65:2], zero pad
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata,  // status, new_task_id, stack_top,
                                            // running_id, previous_id, switched,
                                            // expired, zero pad
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [47:0]      cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  tsprr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_op(in_tdata[1:0]),
    .in_tready(in_tready), .stat(stat), .cmd(cmd)
  );

  tsprr_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
  a_exec_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> stat.out_free) else $error("result overwrote pending word");
  a_exec_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_tvalid) else $error("result word not presented");
`endif

endmodule
`default_nettype wire
